// File: src/abf_pkg.sv
package abf_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned ENTRY_W = ADDR_W + STAMP_W;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_ADD,
    REQ_LOOKUP,
    REQ_EXPIRE
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: src/abf_ram.sv
module abf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/aging_address_blocklist_fifo_unit.sv
// Tick and add requests raise done in the cycle after acceptance; lookup and
// expire requests scan one stored entry per cycle through the single read port of the
// entry RAM, and raise done once the scan ends.
// The block takes no new request until done of the previous one has been shown.
// Reset (synchronous, active high) empties the table, clears the tick counter and sets
// the timeout to 1000; results are shown for one cycle on done and cannot be stalled.
module aging_address_blocklist_fifo_unit import abf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         req_type,
  input  logic [ADDR_W-1:0]                  ip_address,
  input  logic                               cfg_write,
  input  logic [STAMP_W-1:0]                 cfg_data,
  output logic                               done,
  output logic                               found,
  output logic                               add_dropped,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   expired_count,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   occupancy
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = STAMP_W'(1000);

  state_t              state, state_next;
  req_t                req, req_next;
  logic [ADDR_W-1:0]   addr, addr_next;
  logic [IW-1:0]       head_index, head_index_next;
  logic [IW-1:0]       tail_index, tail_index_next;
  logic [CW-1:0]       entry_count, entry_count_next;
  logic [STAMP_W-1:0]  now_ticks, now_ticks_next;
  logic [STAMP_W-1:0]  timeout_ticks;
  logic [IW-1:0]       scan_slot, scan_slot_next;
  logic [CW-1:0]       remain, remain_next;
  logic                found_next;
  logic                add_dropped_next;
  logic [CW-1:0]       expired_count_next;

  logic                ram_we;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0]   rd_address;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [STAMP_W-1:0]  age;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    if (i == IW'(TABLE_DEPTH - 1)) begin
      return '0;
    end
    return i + IW'(1);
  endfunction

  abf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_index),
    .wdata ({ip_address, now_ticks}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_address = ram_rdata[ENTRY_W-1:STAMP_W];
  assign rd_stamp   = ram_rdata[STAMP_W-1:0];
  assign age        = now_ticks - rd_stamp;
  assign ram_raddr  = (state == S_IDLE) ? head_index : scan_slot;
  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign occupancy  = entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
      now_ticks   <= '0;
    end else begin
      state       <= state_next;
      head_index  <= head_index_next;
      tail_index  <= tail_index_next;
      entry_count <= entry_count_next;
      now_ticks   <= now_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    req           <= req_next;
    addr          <= addr_next;
    scan_slot     <= scan_slot_next;
    remain        <= remain_next;
    found         <= found_next;
    add_dropped   <= add_dropped_next;
    expired_count <= expired_count_next;
  end

  always_comb begin
    state_next         = state;
    req_next           = req;
    addr_next          = addr;
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    entry_count_next   = entry_count;
    now_ticks_next     = now_ticks;
    scan_slot_next     = scan_slot;
    remain_next        = remain;
    found_next         = found;
    add_dropped_next   = add_dropped;
    expired_count_next = expired_count;
    ram_we             = 1'b0;
    ram_re             = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next           = req_t'(req_type);
          addr_next          = ip_address;
          found_next         = 1'b0;
          add_dropped_next   = 1'b0;
          expired_count_next = '0;
          case (req_t'(req_type))
            REQ_TICK: begin
              now_ticks_next = now_ticks + STAMP_W'(1);
              state_next     = S_DONE;
            end
            REQ_ADD: begin
              if (entry_count == CW'(TABLE_DEPTH)) begin
                add_dropped_next = 1'b1;
              end else begin
                ram_we           = 1'b1;
                tail_index_next  = wrap_inc(tail_index);
                entry_count_next = entry_count + CW'(1);
              end
              state_next = S_DONE;
            end
            default: begin
              ram_re         = 1'b1;
              scan_slot_next = wrap_inc(head_index);
              remain_next    = entry_count;
              state_next     = (entry_count == '0) ? S_DONE : S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_re         = 1'b1;
        scan_slot_next = wrap_inc(scan_slot);
        remain_next    = remain - CW'(1);
        if (req == REQ_LOOKUP) begin
          if (rd_address == addr) begin
            found_next = 1'b1;
            state_next = S_DONE;
          end else if (remain == CW'(1)) begin
            state_next = S_DONE;
          end
        end else begin
          if (age >= timeout_ticks) begin
            head_index_next    = wrap_inc(head_index);
            entry_count_next   = entry_count - CW'(1);
            expired_count_next = expired_count + CW'(1);
            if (remain == CW'(1)) begin
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  logic [IW:0] tail_expect_sum;
  logic [IW-1:0] tail_expect;

  assign tail_expect_sum = {1'b0, head_index} + (IW+1)'(entry_count);
  assign tail_expect = (tail_expect_sum >= (IW+1)'(TABLE_DEPTH))
                       ? IW'(tail_expect_sum - (IW+1)'(TABLE_DEPTH))
                       : IW'(tail_expect_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    tail_index == tail_expect)
    else $error("tail index disagrees with head index plus count");

  a_tick_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_TICK || req_type == REQ_ADD)) |=> done)
    else $error("tick or add request did not finish in one cycle");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after done");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> ((found && req == REQ_LOOKUP) || (add_dropped && req == REQ_ADD)
              || (!found && !add_dropped)))
    else $error("result flag raised for the wrong request type");

endmodule

// File: bench/testbench.sv
module testbench;
  import abf_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct {
    logic          found;
    logic          dropped;
    logic [CW-1:0] expired;
    logic [CW-1:0] occupancy;
  } outcome_t;

  class blocklist_tracker;
    logic [31:0] timeout_ticks;
    logic [31:0] now_ticks;
    logic [31:0] addr_mem [DEPTH];
    logic [31:0] stamp_mem [DEPTH];
    int          head_slot;
    int          tail_slot;
    int          held;
    int          errors;
    outcome_t    pending_outcomes [$];

    function new();
      timeout_ticks = 32'd1000;
      now_ticks = '0;
      head_slot = 0;
      tail_slot = 0;
      held = 0;
      errors = 0;
    endfunction

    function void note_request(req_t req, logic [31:0] addr);
      outcome_t o;
      o.found = 1'b0;
      o.dropped = 1'b0;
      o.expired = '0;
      case (req)
        REQ_TICK: begin
          now_ticks = now_ticks + 32'd1;
        end
        REQ_ADD: begin
          if (held >= DEPTH) begin
            o.dropped = 1'b1;
          end else begin
            addr_mem[tail_slot] = addr;
            stamp_mem[tail_slot] = now_ticks;
            tail_slot = (tail_slot + 1) % DEPTH;
            held++;
          end
        end
        REQ_LOOKUP: begin
          for (int i = 0; i < held; i++)
            if (addr_mem[(head_slot + i) % DEPTH] == addr) o.found = 1'b1;
        end
        default: begin
          while (held > 0 && (now_ticks - stamp_mem[head_slot]) >= timeout_ticks) begin
            head_slot = (head_slot + 1) % DEPTH;
            held--;
            o.expired = o.expired + 1'b1;
          end
        end
      endcase
      o.occupancy = CW'(held);
      pending_outcomes.push_back(o);
    endfunction

    function void check_result(logic found, logic dropped, logic [CW-1:0] expired,
                               logic [CW-1:0] occupancy);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (found !== o.found) begin
        $error("found: expected %0d, got %0d", o.found, found);
        errors++;
      end
      if (dropped !== o.dropped) begin
        $error("add_dropped: expected %0d, got %0d", o.dropped, dropped);
        errors++;
      end
      if (expired !== o.expired) begin
        $error("expired_count: expected %0d, got %0d", o.expired, expired);
        errors++;
      end
      if (occupancy !== o.occupancy) begin
        $error("occupancy: expected %0d, got %0d", o.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    req_type = REQ_TICK;
  logic [31:0]   ip_address = '0;
  logic          cfg_write = 1'b0;
  logic [31:0]   cfg_data = '0;
  logic          done;
  logic          found;
  logic          add_dropped;
  logic [CW-1:0] expired_count;
  logic [CW-1:0] occupancy;

  blocklist_tracker shadow = new();
  logic [31:0]      known_addrs [$];
  bit               no_gaps = 1'b0;

  aging_address_blocklist_fifo_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .ip_address(ip_address),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .found(found),
    .add_dropped(add_dropped),
    .expired_count(expired_count),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) shadow.note_request(req_t'(req_type), ip_address);
      if (done) shadow.check_result(found, add_dropped, expired_count, occupancy);
    end
  end

  task automatic send_request(req_t req, logic [31:0] addr);
    @(negedge clk);
    start <= 1'b1;
    req_type <= req;
    ip_address <= addr;
    do @(posedge clk); while (busy);
    if (req == REQ_ADD) begin
      known_addrs.push_back(addr);
      if (known_addrs.size() > 24) void'(known_addrs.pop_front());
    end
  endtask

  task automatic pause(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      ip_address <= $urandom();
    end
  endtask

  // hold off until every request has answered, then let the block settle
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (shadow.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data <= $urandom();
    shadow.timeout_ticks = value;
  endtask

  function automatic logic [31:0] pick_address(bit prefer_known);
    if (prefer_known && known_addrs.size() > 0)
      return known_addrs[$urandom_range(known_addrs.size() - 1)];
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] phase_timeout;
    int          tick_pct;
    int          pick;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(REQ_EXPIRE, 32'h0);
    send_request(REQ_LOOKUP, 32'h0);
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'hA5A5_5A5A);
    send_request(REQ_TICK, 32'h0);
    repeat (13) send_request(REQ_ADD, $urandom());
    send_request(REQ_ADD, 32'h1234_5678);
    send_request(REQ_LOOKUP, known_addrs[known_addrs.size() - 2]);
    send_request(REQ_EXPIRE, 32'h0);
    wait_for_results();

    write_timeout(32'h0000_0000);
    send_request(REQ_EXPIRE, 32'h0);
    wait_for_results();
    write_timeout(32'h0000_0001);
    send_request(REQ_ADD, 32'h5555_AAAA);
    send_request(REQ_EXPIRE, 32'h0);
    send_request(REQ_TICK, 32'h0);
    send_request(REQ_EXPIRE, 32'h0);
    wait_for_results();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin phase_timeout = 32'd1; tick_pct = 30; end
        1: begin phase_timeout = $urandom_range(4, 40); tick_pct = 35; end
        2: begin phase_timeout = 32'hFFFF_FFFF; tick_pct = 30; end
        3: begin phase_timeout = 32'd0; tick_pct = 25; end
        4: begin phase_timeout = $urandom_range(60, 150); tick_pct = 70; end
        5: begin phase_timeout = $urandom(); tick_pct = 35; end
        default: begin phase_timeout = 32'd1000; tick_pct = 40; end
      endcase
      no_gaps = (phase == 1);
      write_timeout(phase_timeout);
      for (int n = 0; n < 186; n++) begin
        pick = $urandom_range(99);
        if (pick < tick_pct) begin
          send_request(REQ_TICK, $urandom());
        end else begin
          pick = $urandom_range(99);
          if (pick < 40)
            send_request(REQ_ADD, pick_address($urandom_range(99) < 30));
          else if (pick < 75)
            send_request(REQ_LOOKUP, pick_address($urandom_range(99) < 60));
          else
            send_request(REQ_EXPIRE, $urandom());
        end
        if (!no_gaps && $urandom_range(99) < 18) pause($urandom_range(1, 8));
        if ($urandom_range(99) == 0) wait_for_results();
      end
      wait_for_results();
    end

    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
